/* hdl/pfr_pkg.sv */
// Package for the packet frame reader: shared widths, register indexes,
// result kind codes, and the configuration and result structs.
// Has no dependencies; every other file of the block uses it.
package pfr_pkg;

  localparam int unsigned LengthWidthDefault = 24;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned FlagsW   = 16;
  localparam int unsigned PartW    = 32;
  localparam int unsigned LenW     = 24;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgExpectedVersion = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBigEndian       = 2'd2;

  localparam logic [ByteW-1:0] VersionReset    = 8'd4;
  localparam logic [LenW-1:0]  MaxPayloadReset = 24'hFF_FFFF;
  localparam logic             BigEndianReset  = 1'b1;

  // Result kinds
  localparam logic [1:0] KindHeader  = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindVerErr  = 2'd2;
  localparam logic [1:0] KindLenErr  = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] expected_version;
    logic [LenW-1:0]  max_payload;
    logic             big_endian;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [FlagsW-1:0]       flags_word;
    logic signed [PartW-1:0] partition;
    logic [LenW-1:0]         payload_length;
    logic [ByteW-1:0]        payload_byte;
    logic                    last;
  } result_t;

endpackage

/* hdl/pfr_in_if.sv */
// Byte input channel of the packet frame reader: valid/ready plus one stream byte.
// Depends on pfr_pkg for the byte width.
interface pfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [pfr_pkg::ByteW-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

/* hdl/pfr_out_if.sv */
// Result channel of the packet frame reader: valid/ready plus the result fields.
// Depends on pfr_pkg for the field widths.
interface pfr_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [pfr_pkg::FlagsW-1:0]        flags_word;
  logic signed [pfr_pkg::PartW-1:0]  partition;
  logic [pfr_pkg::LenW-1:0]          payload_length;
  logic [pfr_pkg::ByteW-1:0]         payload_byte;
  logic                              last;

  modport source (
    output valid, output kind, output flags_word, output partition,
    output payload_length, output payload_byte, output last, input ready
  );
  modport sink (
    input valid, input kind, input flags_word, input partition,
    input payload_length, input payload_byte, input last, output ready
  );
endinterface

/* hdl/pfr_parser.sv */
// Frame parser: phase register, header field assembly and payload counter.
// Produces at most one result per accepted byte. Depends on pfr_pkg.
module pfr_parser #(
  parameter int unsigned LENGTH_WIDTH = pfr_pkg::LengthWidthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pfr_pkg::cfg_t             cfg_i,
  input  logic                      accept_i,
  input  logic [pfr_pkg::ByteW-1:0] data_byte_i,
  output logic                      res_valid_o,
  output pfr_pkg::result_t          res_o
);

  localparam logic [2:0] PhVersion   = 3'd0;
  localparam logic [2:0] PhFlags     = 3'd1;
  localparam logic [2:0] PhPartition = 3'd2;
  localparam logic [2:0] PhLength    = 3'd3;
  localparam logic [2:0] PhPayload   = 3'd4;

  localparam logic [31:0] LenLimit = 32'((64'd1 << LENGTH_WIDTH) - 64'd1);

  // Insert one byte into a field; byte index cnt, order per be
  function automatic logic [31:0] place(input logic [31:0] acc, input logic [1:0] cnt,
                                        input logic [7:0] b, input logic be);
    logic [31:0] a;
    a = (cnt == 2'd0) ? 32'd0 : acc;
    if (be) begin
      return {a[23:0], b};
    end
    return a | ({24'd0, b} << {cnt, 3'b000});
  endfunction

  logic [2:0]                     phase_q, phase_d;
  logic [1:0]                     cnt_q, cnt_d;
  logic [pfr_pkg::FlagsW-1:0]     flags_q, flags_d;
  logic [31:0]                    part_q, part_d;
  logic [31:0]                    len_q, len_d;
  logic [LENGTH_WIDTH-1:0]        off_q, off_d;

  logic [31:0]             flags_new, part_new, len_new;
  logic [LENGTH_WIDTH-1:0] off_inc;
  logic                    len_bad, done;

  assign flags_new = place({16'd0, flags_q}, cnt_q, data_byte_i, cfg_i.big_endian);
  assign part_new  = place(part_q, cnt_q, data_byte_i, cfg_i.big_endian);
  assign len_new   = place(len_q, cnt_q, data_byte_i, cfg_i.big_endian);
  assign len_bad   = len_new[31] || (len_new > {8'd0, cfg_i.max_payload}) ||
                     (len_new > LenLimit);
  assign off_inc   = off_q + 1'b1;
  assign done      = (32'(off_inc) == len_q);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    flags_d = flags_q;
    part_d  = part_q;
    len_d   = len_q;
    off_d   = off_q;
    res_valid_o          = 1'b0;
    res_o.kind           = pfr_pkg::KindHeader;
    res_o.flags_word     = flags_q;
    res_o.partition      = $signed(part_q);
    res_o.payload_length = len_q[pfr_pkg::LenW-1:0];
    res_o.payload_byte   = '0;
    res_o.last           = 1'b0;
    case (phase_q)
      PhFlags: begin
        flags_d = flags_new[pfr_pkg::FlagsW-1:0];
        if (cnt_q >= 2'd1) begin
          cnt_d   = 2'd0;
          phase_d = PhPartition;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      PhPartition: begin
        part_d = part_new;
        if (cnt_q == 2'd3) begin
          phase_d = PhLength;
        end
        cnt_d = cnt_q + 2'd1;
      end
      PhLength: begin
        len_d = len_new;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          res_valid_o      = 1'b1;
          res_o.flags_word = flags_q;
          res_o.partition  = $signed(part_q);
          if (len_bad) begin
            res_o.kind           = pfr_pkg::KindLenErr;
            res_o.payload_length = '0;
            res_o.last           = 1'b1;
            phase_d              = PhVersion;
          end else begin
            off_d                = '0;
            res_o.kind           = pfr_pkg::KindHeader;
            res_o.payload_length = len_new[pfr_pkg::LenW-1:0];
            res_o.last           = (len_new == 32'd0);
            phase_d              = (len_new == 32'd0) ? PhVersion : PhPayload;
          end
        end
      end
      PhPayload: begin
        res_valid_o        = 1'b1;
        res_o.kind         = pfr_pkg::KindPayload;
        res_o.payload_byte = data_byte_i;
        res_o.last         = done;
        off_d              = done ? '0 : off_inc;
        if (done) begin
          phase_d = PhVersion;
        end
      end
      default: begin
        // Version byte; unused phase codes land here too
        cnt_d   = 2'd0;
        phase_d = PhVersion;
        if (data_byte_i != cfg_i.expected_version) begin
          res_valid_o          = 1'b1;
          res_o.kind           = pfr_pkg::KindVerErr;
          res_o.flags_word     = '0;
          res_o.partition      = -32'sd1;
          res_o.payload_length = '0;
          res_o.last           = 1'b1;
        end else begin
          flags_d = '0;
          part_d  = '1;
          len_d   = '0;
          off_d   = '0;
          phase_d = PhFlags;
        end
      end
    endcase
    if (!accept_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhVersion;
      cnt_q   <= 2'd0;
      flags_q <= '0;
      part_q  <= '1;
      len_q   <= '0;
      off_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
      part_q  <= part_d;
      len_q   <= len_d;
      off_q   <= off_d;
    end
  end

endmodule

/* hdl/pfr_out_buf.sv */
// Two-entry result stage: an output register plus a skid register, so the
// input side keeps moving while a result waits. Depends on pfr_pkg.
module pfr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pfr_pkg::result_t push_data_i,
  output logic             can_push_o,
  output logic             valid_o,
  output pfr_pkg::result_t data_o,
  input  logic             ready_i
);

  logic             main_v_q, skid_v_q;
  pfr_pkg::result_t main_q, skid_q;
  logic             pop;

  assign pop        = main_v_q && ready_i;
  assign can_push_o = !skid_v_q;
  assign valid_o    = main_v_q;
  assign data_o     = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= push_data_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_q <= push_data_i;
      end else begin
        main_q <= push_data_i;
      end
    end
  end

endmodule

/* hdl/packet_frame_reader.sv */
// Packet frame reader: takes one stream byte per cycle and parses back-to-back
// length-prefixed frames. Throughput is one byte per clock; each result is
// registered in the result stage before it reaches out_if. That two-entry stage keeps
// the byte input ready while one result waits; input stalls only once both are full.
// Configuration writes are taken at any edge with cfg_we_i high and act on the next byte.
// Depends on pfr_pkg, pfr_in_if, pfr_out_if, pfr_parser and pfr_out_buf.
module packet_frame_reader #(
  parameter int unsigned LENGTH_WIDTH = pfr_pkg::LengthWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pfr_pkg::CfgDataW-1:0] cfg_data_i,
  pfr_in_if.sink                       in_if,
  pfr_out_if.source                    out_if
);

  pfr_pkg::cfg_t    cfg_q;
  pfr_pkg::result_t res, out_data;
  logic             res_valid, can_push, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version <= pfr_pkg::VersionReset;
      cfg_q.max_payload      <= pfr_pkg::MaxPayloadReset;
      cfg_q.big_endian       <= pfr_pkg::BigEndianReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pfr_pkg::CfgExpectedVersion: cfg_q.expected_version <= cfg_data_i[7:0];
        pfr_pkg::CfgMaxPayload:      cfg_q.max_payload      <= cfg_data_i;
        pfr_pkg::CfgBigEndian:       cfg_q.big_endian       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = can_push;
  assign accept      = in_if.valid && can_push;

  pfr_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (in_if.data_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .can_push_o  (can_push),
    .valid_o     (out_if.valid),
    .data_o      (out_data),
    .ready_i     (out_if.ready)
  );

  assign out_if.kind           = out_data.kind;
  assign out_if.flags_word     = out_data.flags_word;
  assign out_if.partition      = out_data.partition;
  assign out_if.payload_length = out_data.payload_length;
  assign out_if.payload_byte   = out_data.payload_byte;
  assign out_if.last           = out_data.last;

endmodule
